// File: src/fmv_pkg.sv
// Shared types, constants and table functions for the two-operator FM voice.
// No dependencies; used by fmv_mul and fm_synth_voice.
package fmv_pkg;

  localparam int unsigned SINE_ADDR_BITS_DEF = 10;
  localparam int unsigned TANH_ADDR_BITS_DEF = 10;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned ENV_BITS = 24;
  localparam int unsigned PHASE_BITS = 32;
  localparam int unsigned OUT_BITS = 16;
  localparam int unsigned CFG_DATA_BITS = 24;
  localparam int unsigned MUL_B_BITS = 32;
  localparam int unsigned MUL_DIGIT_BITS = 8;
  // phase offset in radians Q16 before the 1/(2 pi) scale
  localparam int unsigned P_BITS = 26;

  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  localparam logic [15:0] MOD_INDEX_RST = 16'd12288;
  localparam logic [23:0] ATTACK_RST = 24'd16701297;
  localparam logic [23:0] RELEASE_RST = 24'd16775314;
  localparam logic [15:0] LOWPASS_RST = 16'd53680;
  localparam logic [15:0] DRIVE_RST = 16'd24576;
  localparam logic [15:0] AMPLITUDE_RST = 16'd26214;
  localparam logic [23:0] SILENCE_RST = 24'd168;

  typedef enum logic [2:0] {
    REG_MOD_INDEX     = 3'd0,
    REG_ATTACK_COEFF  = 3'd1,
    REG_RELEASE_COEFF = 3'd2,
    REG_LOWPASS_COEFF = 3'd3,
    REG_DRIVE_GAIN    = 3'd4,
    REG_AMPLITUDE     = 3'd5,
    REG_SILENCE_LEVEL = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_NOTE_ON  = 2'd1,
    ACT_NOTE_OFF = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV,
    ST_EFF,
    ST_MRD,
    ST_PMUL,
    ST_OMUL,
    ST_CRD,
    ST_CACC,
    ST_DRV,
    ST_TRD,
    ST_GMUL,
    ST_AMUL,
    ST_LMUL,
    ST_OUT
  } state_e;

  // round half away from zero, shift right by n (n >= 1)
  function automatic logic signed [63:0] rnd_shr(logic signed [63:0] v, int unsigned n);
    logic [63:0] mag;
    begin
      mag = v[63] ? (64'd0 - v) : v;
      mag = (mag + (64'd1 << (n - 1))) >> n;
      return v[63] ? $signed(64'd0 - mag) : $signed(mag);
    end
  endfunction

  // restoring long division, table build only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] q;
    begin
      rem = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
        rem = {rem[62:0], n[i]};
        if (rem >= d) begin
          rem = rem - d;
          q[i] = 1'b1;
        end
      end
      return q;
    end
  endfunction

  function automatic logic signed [63:0] sine_entry(int unsigned addr, int unsigned abits,
                                                    int unsigned sb);
    logic [63:0] quarter, quad, r, m, x, x2, t, s, full, e;
    int unsigned qbits;
    begin
      qbits = abits - 2;
      quarter = 64'd1 << qbits;
      quad = (64'(addr) >> qbits) & 64'd3;
      r = 64'(addr) & (quarter - 64'd1);
      m = quad[0] ? (quarter - r) : r;
      x = (m * HALF_PI_Q30) >> qbits;
      x2 = (x * x) >> 30;
      t = Q30_ONE - x2 / 72;
      t = Q30_ONE - ((x2 * t) >> 30) / 42;
      t = Q30_ONE - ((x2 * t) >> 30) / 20;
      t = Q30_ONE - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      full = (64'd1 << (sb - 1)) - 64'd1;
      e = (s * full + (Q30_ONE >> 1)) >> 30;
      if (e > full) e = full;
      return quad[1] ? $signed(64'd0 - e) : $signed(e);
    end
  endfunction

  function automatic logic [63:0] tanh_entry(int unsigned addr, int unsigned tbits,
                                             int unsigned sb);
    logic [63:0] t, u, den, full;
    begin
      t = 64'(addr) << (29 - tbits);
      u = Q30_ONE;
      u = Q30_ONE - ((t * u) >> 30) / 8;
      u = Q30_ONE - ((t * u) >> 30) / 7;
      u = Q30_ONE - ((t * u) >> 30) / 6;
      u = Q30_ONE - ((t * u) >> 30) / 5;
      u = Q30_ONE - ((t * u) >> 30) / 4;
      u = Q30_ONE - ((t * u) >> 30) / 3;
      u = Q30_ONE - ((t * u) >> 30) / 2;
      u = Q30_ONE - ((t * u) >> 30);
      for (int i = 0; i < 4; i++) u = (u * u) >> 30;
      den = Q30_ONE + u;
      full = (64'd1 << (sb - 1)) - 64'd1;
      return udiv64((Q30_ONE - u) * full + (den >> 1), den);
    end
  endfunction

endpackage

// File: src/fm_synth_voice.sv
// Two-operator FM voice: sequencer, state, config registers, sine and tanh ROMs.
// Depends on fmv_pkg and fmv_mul.
//
// Usage: input words on the s_axis channel, tuser carries the action (tick,
// note on, note off), tdata the note data. A note on or note off updates the
// voice state when taken and yields no output word. A tick yields one output
// word on m_axis, the filtered sample.
// Timing: every product goes through one shared digit-serial multiplier,
// 8 bits of operand per cycle. A sounding tick runs ten products plus ROM
// reads; a silent released tick runs only the envelope product. The voice
// takes one word at a time; s_axis_tready is high only while no tick is
// in work.
// The result sits in an output register; a stalled receiver holds the next
// tick at its final step until the register frees, earlier results are kept.
// Config writes (cfg_*) are always taken and must come while idle.
// Reset: config registers return to defaults, voice silent and inactive,
// phases, envelope and filter at zero. The ROMs are constant tables.
module fm_synth_voice #(
  parameter int unsigned SINE_ADDR_BITS = fmv_pkg::SINE_ADDR_BITS_DEF,
  parameter int unsigned TANH_ADDR_BITS = fmv_pkg::TANH_ADDR_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = fmv_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] carrier_step, [63:32] modulator_step, [79:64] pitch_scale
  input  logic [79:0]                       s_axis_tdata,
  // [1:0] action
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] sample
  output logic [15:0]                       m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_index_i,
  input  logic [fmv_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned SINE_DEPTH = 2 ** SINE_ADDR_BITS;
  localparam int unsigned TANH_DEPTH = 2 ** TANH_ADDR_BITS;
  localparam int unsigned AW = (SB + 1 > fmv_pkg::P_BITS) ? SB + 1 : fmv_pkg::P_BITS;
  localparam int unsigned PW = AW + fmv_pkg::MUL_B_BITS;
  localparam int unsigned EB = fmv_pkg::ENV_BITS;
  localparam int unsigned PHB = fmv_pkg::PHASE_BITS;
  localparam int unsigned TSH = SB + 16 - TANH_ADDR_BITS;
  localparam int unsigned YL = (SB < 16) ? 16 - SB : 0;
  localparam int unsigned YR = (SB > 16) ? SB - 16 : 1;

  typedef logic signed [SB-1:0] sine_tab_t [SINE_DEPTH];
  typedef logic [SB-2:0] tanh_tab_t [TANH_DEPTH];

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    begin
      for (int i = 0; i < SINE_DEPTH; i++)
        tab[i] = SB'(fmv_pkg::sine_entry(i, SINE_ADDR_BITS, SB));
      return tab;
    end
  endfunction

  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t tab;
    begin
      for (int i = 0; i < TANH_DEPTH; i++)
        tab[i] = (SB-1)'(fmv_pkg::tanh_entry(i, TANH_ADDR_BITS, SB));
      return tab;
    end
  endfunction

  localparam sine_tab_t SineTab = build_sine_tab();
  localparam tanh_tab_t TanhTab = build_tanh_tab();

  // config
  logic [15:0]   mod_index_q, lowpass_q, drive_q, amplitude_q;
  logic [EB-1:0] attack_q, release_q, silence_q;

  // voice state
  fmv_pkg::state_e state_q, state_d;
  logic [PHB-1:0] car_phase_q, mod_phase_q, car_inc_q, mod_inc_q;
  logic [15:0]    pitch_q;
  logic [EB-1:0]  env_q;
  logic           active_q;
  logic signed [15:0] filt_q;

  // per-tick working registers
  logic           started_q;
  logic           osr_q;
  logic [31:0]    eff_q;
  logic signed [fmv_pkg::P_BITS-1:0] p_q;
  logic [PHB-1:0] off_q;
  logic signed [SB:0] sum_q;
  logic [TANH_ADDR_BITS-1:0] taddr_q;
  logic           neg_q;
  logic signed [SB-1:0] v_q;
  logic signed [16:0] y_q;
  logic [15:0]    res_q;
  logic           out_valid_q;
  logic [15:0]    out_data_q;

  // ROM read registers
  logic signed [SB-1:0] sine_q;
  logic [SB-2:0]        tanh_q;
  logic [SINE_ADDR_BITS-1:0] sine_addr;
  logic [PHB-1:0]       car_sum;

  // multiplier
  logic                 mul_start, mul_done, mul_state;
  logic signed [AW-1:0] mul_a;
  logic [31:0]          mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [63:0]   prod;

  logic          s_accept, out_free, silent;
  logic [EB-1:0] env_new;
  logic [EB-1:0] rem;
  logic [63:0]   xmag, tround;
  logic signed [63:0] v2, y_calc, lp_sum;
  logic signed [SB-1:0] t_val;
  logic signed [17:0] diff;

  fmv_mul #(.A_BITS(AW)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  assign prod = 64'(mul_p);
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign car_sum = car_phase_q + off_q;

  // envelope update from the product
  assign rem = prod[2*EB-1:EB];
  always_comb begin
    if (active_q) begin
      env_new = (rem == '0) ? {EB{1'b1}} : (EB'(0) - rem);
    end else begin
      env_new = rem;
    end
  end
  assign silent = !active_q && (env_new < silence_q);

  assign t_val = neg_q ? -$signed({1'b0, tanh_q}) : $signed({1'b0, tanh_q});
  assign diff = {y_q[16], y_q} - {{2{filt_q[15]}}, filt_q};

  always_comb begin
    xmag = prod[63] ? (64'd0 - prod) : prod;
    tround = (xmag + (64'd1 << (TSH - 1))) >> TSH;
    v2 = fmv_pkg::rnd_shr(prod, 16);
    y_calc = (SB > 16) ? fmv_pkg::rnd_shr(v2, YR) : (v2 <<< YL);
    lp_sum = 64'(filt_q) + fmv_pkg::rnd_shr(prod, 16);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fmv_pkg::ST_IDLE:
        if (s_accept && s_axis_tuser == fmv_pkg::ACT_TICK) state_d = fmv_pkg::ST_ENV;
      fmv_pkg::ST_ENV:
        if (mul_done) state_d = silent ? fmv_pkg::ST_OUT : fmv_pkg::ST_EFF;
      fmv_pkg::ST_EFF:  if (mul_done) state_d = fmv_pkg::ST_MRD;
      fmv_pkg::ST_MRD:  state_d = fmv_pkg::ST_PMUL;
      fmv_pkg::ST_PMUL: if (mul_done) state_d = fmv_pkg::ST_OMUL;
      fmv_pkg::ST_OMUL: if (mul_done) state_d = fmv_pkg::ST_CRD;
      fmv_pkg::ST_CRD:  state_d = fmv_pkg::ST_CACC;
      fmv_pkg::ST_CACC: state_d = osr_q ? fmv_pkg::ST_DRV : fmv_pkg::ST_MRD;
      fmv_pkg::ST_DRV:  if (mul_done) state_d = fmv_pkg::ST_TRD;
      fmv_pkg::ST_TRD:  state_d = fmv_pkg::ST_GMUL;
      fmv_pkg::ST_GMUL: if (mul_done) state_d = fmv_pkg::ST_AMUL;
      fmv_pkg::ST_AMUL: if (mul_done) state_d = fmv_pkg::ST_LMUL;
      fmv_pkg::ST_LMUL: if (mul_done) state_d = fmv_pkg::ST_OUT;
      fmv_pkg::ST_OUT:  if (out_free) state_d = fmv_pkg::ST_IDLE;
      default:          state_d = fmv_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake, multiplier operands, ROM address
  always_comb begin
    s_axis_tready = (state_q == fmv_pkg::ST_IDLE);
    mul_state = 1'b1;
    mul_a = '0;
    mul_b = '0;
    sine_addr = mod_phase_q[PHB-1 -: SINE_ADDR_BITS];
    case (state_q)
      fmv_pkg::ST_ENV: begin
        if (active_q) begin
          mul_a = AW'((EB+1)'(1) << EB) - AW'(env_q);
          mul_b = 32'(attack_q);
        end else begin
          mul_a = AW'(env_q);
          mul_b = 32'(release_q);
        end
      end
      fmv_pkg::ST_EFF: begin
        mul_a = AW'(mod_index_q);
        mul_b = 32'(pitch_q);
      end
      fmv_pkg::ST_PMUL: begin
        mul_a = {{(AW-SB){sine_q[SB-1]}}, sine_q};
        mul_b = eff_q;
      end
      fmv_pkg::ST_OMUL: begin
        mul_a = {{(AW-fmv_pkg::P_BITS){p_q[fmv_pkg::P_BITS-1]}}, p_q};
        mul_b = fmv_pkg::INV_TWO_PI_Q32;
      end
      fmv_pkg::ST_DRV: begin
        mul_a = {{(AW-SB-1){sum_q[SB]}}, sum_q};
        mul_b = 32'(drive_q);
      end
      fmv_pkg::ST_GMUL: begin
        mul_a = {{(AW-SB){t_val[SB-1]}}, t_val};
        mul_b = 32'(env_q);
      end
      fmv_pkg::ST_AMUL: begin
        mul_a = {{(AW-SB){v_q[SB-1]}}, v_q};
        mul_b = 32'(amplitude_q);
      end
      fmv_pkg::ST_LMUL: begin
        mul_a = {{(AW-18){diff[17]}}, diff};
        mul_b = 32'(lowpass_q);
      end
      fmv_pkg::ST_CRD: begin
        mul_state = 1'b0;
        sine_addr = car_sum[PHB-1 -: SINE_ADDR_BITS];
      end
      default: mul_state = 1'b0;
    endcase
    mul_start = mul_state && !started_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_index_q <= fmv_pkg::MOD_INDEX_RST;
      attack_q <= fmv_pkg::ATTACK_RST;
      release_q <= fmv_pkg::RELEASE_RST;
      lowpass_q <= fmv_pkg::LOWPASS_RST;
      drive_q <= fmv_pkg::DRIVE_RST;
      amplitude_q <= fmv_pkg::AMPLITUDE_RST;
      silence_q <= fmv_pkg::SILENCE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fmv_pkg::REG_MOD_INDEX:     mod_index_q <= cfg_data_i[15:0];
        fmv_pkg::REG_ATTACK_COEFF:  attack_q <= cfg_data_i;
        fmv_pkg::REG_RELEASE_COEFF: release_q <= cfg_data_i;
        fmv_pkg::REG_LOWPASS_COEFF: lowpass_q <= cfg_data_i[15:0];
        fmv_pkg::REG_DRIVE_GAIN:    drive_q <= cfg_data_i[15:0];
        fmv_pkg::REG_AMPLITUDE:     amplitude_q <= cfg_data_i[15:0];
        fmv_pkg::REG_SILENCE_LEVEL: silence_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmv_pkg::ST_IDLE;
      started_q <= 1'b0;
      osr_q <= 1'b0;
      car_phase_q <= '0;
      mod_phase_q <= '0;
      car_inc_q <= '0;
      mod_inc_q <= '0;
      pitch_q <= '0;
      env_q <= '0;
      active_q <= 1'b0;
      filt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_start) started_q <= 1'b1;
      else if (mul_done) started_q <= 1'b0;

      if (s_accept) begin
        case (s_axis_tuser)
          fmv_pkg::ACT_NOTE_ON: begin
            car_inc_q <= s_axis_tdata[31:0];
            mod_inc_q <= s_axis_tdata[63:32];
            pitch_q <= s_axis_tdata[79:64];
            car_phase_q <= '0;
            mod_phase_q <= '0;
            env_q <= '0;
            active_q <= 1'b1;
          end
          fmv_pkg::ACT_NOTE_OFF: active_q <= 1'b0;
          default: ;
        endcase
      end

      case (state_q)
        fmv_pkg::ST_ENV: begin
          osr_q <= 1'b0;
          if (mul_done) env_q <= env_new;
        end
        fmv_pkg::ST_MRD: mod_phase_q <= mod_phase_q + mod_inc_q;
        fmv_pkg::ST_CRD: car_phase_q <= car_phase_q + car_inc_q;
        fmv_pkg::ST_CACC: osr_q <= 1'b1;
        fmv_pkg::ST_LMUL: begin
          if (mul_done) begin
            if (lp_sum > 64'sd32767) filt_q <= 16'sh7fff;
            else if (lp_sum < -64'sd32768) filt_q <= -16'sh8000;
            else filt_q <= lp_sum[15:0];
          end
        end
        default: ;
      endcase

      if (state_q == fmv_pkg::ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // datapath words, no reset needed
  always_ff @(posedge clk_i) begin
    sine_q <= SineTab[sine_addr];
    tanh_q <= TanhTab[taddr_q];
    case (state_q)
      fmv_pkg::ST_ENV: begin
        sum_q <= '0;
        if (mul_done && silent) res_q <= '0;
      end
      fmv_pkg::ST_EFF:  if (mul_done) eff_q <= prod[31:0];
      fmv_pkg::ST_PMUL:
        if (mul_done) p_q <= fmv_pkg::P_BITS'(fmv_pkg::rnd_shr(prod, SB + 7));
      fmv_pkg::ST_OMUL: if (mul_done) off_q <= PHB'(fmv_pkg::rnd_shr(prod, 16));
      fmv_pkg::ST_CACC: sum_q <= sum_q + {sine_q[SB-1], sine_q};
      fmv_pkg::ST_DRV: begin
        if (mul_done) begin
          neg_q <= prod[63];
          if (tround > 64'(TANH_DEPTH - 1)) taddr_q <= {TANH_ADDR_BITS{1'b1}};
          else taddr_q <= tround[TANH_ADDR_BITS-1:0];
        end
      end
      fmv_pkg::ST_GMUL: if (mul_done) v_q <= SB'(fmv_pkg::rnd_shr(prod, EB));
      fmv_pkg::ST_AMUL: if (mul_done) y_q <= y_calc[16:0];
      fmv_pkg::ST_LMUL: begin
        if (mul_done) begin
          if (lp_sum > 64'sd32767) res_q <= 16'h7fff;
          else if (lp_sum < -64'sd32768) res_q <= 16'h8000;
          else res_q <= lp_sum[15:0];
        end
      end
      fmv_pkg::ST_OUT: if (out_free) out_data_q <= res_q;
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

`ifndef SYNTHESIS
  a_mul_done_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> started_q)
    else $error("multiplier finished without a start");
  a_two_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fmv_pkg::ST_DRV) |-> osr_q)
    else $error("drive step reached before both oversampled steps");
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fmv_pkg::ST_OUT && out_free) |=> m_axis_tvalid)
    else $error("finished word not presented");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != fmv_pkg::ST_IDLE) |-> !s_axis_tready)
    else $error("input taken during a tick");
`endif

endmodule

// File: src/fmv_mul.sv
// Digit-serial signed-by-unsigned multiplier, one 8-bit digit of b per cycle, MSB first.
// Uses fmv_pkg constants; instantiated by fm_synth_voice.
module fmv_mul #(
  parameter int unsigned A_BITS = 26
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic signed [A_BITS-1:0]                     a_i,
  input  logic [fmv_pkg::MUL_B_BITS-1:0]               b_i,
  output logic                                         done_o,
  output logic signed [A_BITS+fmv_pkg::MUL_B_BITS-1:0] p_o
);

  localparam int unsigned BB = fmv_pkg::MUL_B_BITS;
  localparam int unsigned DB = fmv_pkg::MUL_DIGIT_BITS;
  localparam int unsigned PB = A_BITS + BB;
  localparam int unsigned STEPS = BB / DB;
  localparam int unsigned CNT_BITS = $clog2(STEPS + 1);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [CNT_BITS-1:0]     cnt_q, cnt_d;
  logic signed [A_BITS-1:0] a_q;
  logic [BB-1:0]           b_q;
  logic signed [PB-1:0]    acc_q;
  logic signed [PB-1:0]    part;

  assign part = PB'(a_q) * PB'($signed({1'b0, b_q[BB-1 -: DB]}));

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = CNT_BITS'(STEPS);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q <<< DB) + part;
      b_q <= b_q << DB;
    end
  end

  assign done_o = done_q;
  assign p_o = acc_q;

endmodule

// File: tb/fmv_checker.sv
// Scoreboard for fm_synth_voice: watches input, output and config channels,
// predicts each sample and compares it. Depends on fmv_pkg.
module fmv_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ONE30 = 64'd1 << 30;
  localparam longint unsigned FULL = 64'd32767;
  localparam longint unsigned ENV_FULL = 64'd1 << 24;

  logic signed [15:0] sine_lut [1024];
  logic [15:0]        tanh_lut [1024];

  // register copies
  logic [15:0] idx_r, lpf_r, drv_r, amp_r;
  logic [23:0] atk_r, rel_r, sil_r;
  // voice state
  logic [31:0] car_ph, mod_ph, car_inc, mod_inc;
  logic [15:0] pscale;
  logic [23:0] env;
  logic        active;
  logic signed [15:0] lp_level;

  logic signed [15:0] samples_due [$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o = samples_due.size();

  function automatic longint rnd_sh(longint v, int n);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : v;
    mag = (mag + (64'd1 << (n - 1))) >> n;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  initial begin
    longint unsigned m, x, x2, t, s, e, u, den;
    int unsigned quad;
    for (int a = 0; a < 1024; a++) begin
      quad = (a >> 8) & 3;
      m = (quad & 1) ? 256 - (a & 255) : (a & 255);
      x = (m * 64'd1686629713) >> 8;
      x2 = (x * x) >> 30;
      t = ONE30 - x2 / 72;
      t = ONE30 - ((x2 * t) >> 30) / 42;
      t = ONE30 - ((x2 * t) >> 30) / 20;
      t = ONE30 - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      e = (s * FULL + (ONE30 >> 1)) >> 30;
      if (e > FULL) e = FULL;
      sine_lut[a] = (quad & 2) ? -16'(e) : 16'(e);
      // tanh(4a/1024) via e^(-2x) built from a Taylor exp raised to the 16th
      t = 64'(a) << 19;
      u = ONE30;
      for (int k = 8; k >= 1; k--) u = ONE30 - ((t * u) >> 30) / k;
      for (int i = 0; i < 4; i++) u = (u * u) >> 30;
      den = ONE30 + u;
      tanh_lut[a] = 16'(((ONE30 - u) * FULL + den / 2) / den);
    end
  end

  task automatic run_tick(output logic signed [15:0] smp, output logic silent);
    longint unsigned rem, effv, mag, adr;
    longint sum, mv, p, off, x, t, v, y, lp;
    sum = 0;
    silent = 1'b0;
    smp = '0;
    if (!active) begin
      env = 24'((64'(env) * rel_r) >> 24);
      if (env < sil_r) begin
        silent = 1'b1;
        return;
      end
    end else begin
      rem = ((ENV_FULL - env) * atk_r) >> 24;
      env = (rem == 0) ? 24'hFFFFFF : 24'(ENV_FULL - rem);
    end
    effv = 64'(idx_r) * pscale;
    for (int i = 0; i < 2; i++) begin
      mv = sine_lut[mod_ph[31:22]];
      mod_ph = mod_ph + mod_inc;
      p = rnd_sh(longint'(effv) * mv, 23);
      off = rnd_sh(p * 64'sd683565276, 16);
      sum += sine_lut[10'((car_ph + 32'(off)) >> 22)];
      car_ph = car_ph + car_inc;
    end
    x = sum * longint'(drv_r);
    mag = (x < 0) ? longint'(-x) : x;
    adr = (mag + (64'd1 << 21)) >> 22;
    if (adr > 1023) adr = 1023;
    t = tanh_lut[adr];
    if (x < 0) t = -t;
    v = rnd_sh(t * longint'(env), 24);
    v = rnd_sh(v * longint'(amp_r), 16);
    y = rnd_sh(v * 65536, 16);
    lp = lp_level;
    lp += rnd_sh(longint'(lpf_r) * (y - lp), 16);
    if (lp > 32767) lp = 32767;
    if (lp < -32768) lp = -32768;
    lp_level = 16'(lp);
    smp = lp_level;
  endtask

  // handshakes are looked at mid-cycle, where inputs and outputs are settled
  always @(negedge clk_i) begin
    logic signed [15:0] smp, want;
    logic silent;
    if (!rst_ni) begin
      idx_r = fmv_pkg::MOD_INDEX_RST; atk_r = fmv_pkg::ATTACK_RST;
      rel_r = fmv_pkg::RELEASE_RST; lpf_r = fmv_pkg::LOWPASS_RST;
      drv_r = fmv_pkg::DRIVE_RST; amp_r = fmv_pkg::AMPLITUDE_RST;
      sil_r = fmv_pkg::SILENCE_RST;
      car_ph = '0; mod_ph = '0; car_inc = '0; mod_inc = '0;
      pscale = '0; env = '0; active = 1'b0; lp_level = '0;
      samples_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (samples_due.size() == 0) begin
          $error("sample word with none expected, actual %0d", $signed(m_axis_tdata));
          fails++;
        end else begin
          want = samples_due.pop_front();
          if (want !== $signed(m_axis_tdata)) begin
            $error("sample expected %0d actual %0d", want, $signed(m_axis_tdata));
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          fmv_pkg::REG_MOD_INDEX:     idx_r = cfg_data_i[15:0];
          fmv_pkg::REG_ATTACK_COEFF:  atk_r = cfg_data_i;
          fmv_pkg::REG_RELEASE_COEFF: rel_r = cfg_data_i;
          fmv_pkg::REG_LOWPASS_COEFF: lpf_r = cfg_data_i[15:0];
          fmv_pkg::REG_DRIVE_GAIN:    drv_r = cfg_data_i[15:0];
          fmv_pkg::REG_AMPLITUDE:     amp_r = cfg_data_i[15:0];
          fmv_pkg::REG_SILENCE_LEVEL: sil_r = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          fmv_pkg::ACT_NOTE_ON: begin
            car_inc = s_axis_tdata[31:0];
            mod_inc = s_axis_tdata[63:32];
            pscale = s_axis_tdata[79:64];
            car_ph = '0; mod_ph = '0; env = '0;
            active = 1'b1;
          end
          fmv_pkg::ACT_NOTE_OFF: active = 1'b0;
          fmv_pkg::ACT_TICK: begin
            run_tick(smp, silent);
            samples_due.push_back(silent ? 16'sd0 : smp);
          end
          default: ;
        endcase
      end
    end
  end

  initial fails = 0;
endmodule

// File: tb/tb_top.sv
// Top of the fm_synth_voice testbench: clock, reset, stimulus and verdict.
// Depends on fmv_pkg, fm_synth_voice and fmv_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_GOAL = 1450;

  logic clk, rst_n;
  logic s_valid, s_ready, m_valid, m_ready;
  logic [79:0] s_data;
  logic [1:0] s_user;
  logic [15:0] m_data;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [23:0] cfg_data;
  int fails, pending, items, cycles;
  logic calm_in = 1'b0, calm_out = 1'b0;

  fm_synth_voice dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  fmv_checker scoreboard (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fails), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL fm_synth_voice");
      $finish;
    end
  end

  // valid is only lowered when a gap follows, so back-to-back words keep it high
  task automatic send_word(logic [1:0] act, logic [31:0] cstep, logic [31:0] mstep,
                           logic [15:0] pscale);
    int gap;
    logic ok;
    gap = calm_in ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user <= act;
    s_data <= {pscale, mstep, cstep};
    do begin
      @(negedge clk);
      ok = s_ready;
      @(posedge clk);
    end while (!ok);
    if (act != ACT_UNUSED) items++;
    if ($urandom_range(0, 40) == 0) calm_in = ~calm_in;
  endtask

  task automatic tick();
    send_word(fmv_pkg::ACT_TICK, $urandom, $urandom, 16'($urandom));
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    logic ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mode 0 random, 1 all ones, 2 all zeros, 3 random with quick release
  task automatic set_regs(int mode);
    logic [23:0] val;
    for (int i = 0; i < 7; i++) begin
      case (mode)
        1: val = '1;
        2: val = '0;
        default: val = $urandom;
      endcase
      if (mode == 3) begin
        case (fmv_pkg::cfg_reg_e'(i))
          fmv_pkg::REG_RELEASE_COEFF: val = 24'($urandom_range(0, 16000000));
          fmv_pkg::REG_SILENCE_LEVEL: val = 24'($urandom_range(0, 3000000));
          fmv_pkg::REG_ATTACK_COEFF:  val = 24'($urandom_range(12000000, 16777215));
          default: ;
        endcase
      end
      write_reg(fmv_pkg::cfg_reg_e'(i), val);
    end
  endtask

  task automatic play_note();
    int n;
    send_word(fmv_pkg::ACT_NOTE_ON, $urandom, $urandom, 16'($urandom));
    n = $urandom_range(1, 25);
    repeat (n) tick();
    if ($urandom_range(0, 9) == 0) send_word(ACT_UNUSED, $urandom, $urandom, 16'($urandom));
    send_word(fmv_pkg::ACT_NOTE_OFF, $urandom, $urandom, 16'($urandom));
    n = $urandom_range(0, 15);
    repeat (n) tick();
    if ($urandom_range(0, 12) == 0) send_word(fmv_pkg::ACT_NOTE_OFF, '0, '0, '0);
  endtask

  initial begin
    forever begin
      int gap;
      logic ok;
      gap = calm_out ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_ready <= 1'b1;
      do begin
        @(negedge clk);
        ok = m_valid;
        @(posedge clk);
      end while (!ok);
      if ($urandom_range(0, 30) == 0) calm_out = ~calm_out;
    end
  end

  initial begin
    int goal;
    rst_n = 1'b0;
    s_valid = 1'b0; s_data = '0; s_user = fmv_pkg::ACT_TICK;
    m_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = fmv_pkg::REG_MOD_INDEX; cfg_data = '0;
    items = 0; cycles = 0; calm_in = 1'b0; calm_out = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: silent idle voice, unused action, operand extremes
    send_word(fmv_pkg::ACT_TICK, '0, '0, '0);
    send_word(ACT_UNUSED, '1, '1, '1);
    send_word(fmv_pkg::ACT_NOTE_ON, '1, '1, '1);
    repeat (3) send_word(fmv_pkg::ACT_TICK, '1, '1, '1);
    send_word(fmv_pkg::ACT_NOTE_ON, '0, '0, '0);
    repeat (2) tick();
    send_word(fmv_pkg::ACT_NOTE_ON, 32'h8000_0000, 32'h4000_0000, 16'h1000);
    repeat (4) tick();
    send_word(fmv_pkg::ACT_NOTE_OFF, '0, '0, '0);
    repeat (3) tick();
    drain();
    // extreme registers, then release that goes silent at once
    set_regs(1);
    write_reg(REG_NONE, '1);
    send_word(fmv_pkg::ACT_NOTE_ON, 32'h0123_4567, 32'h89AB_CDEF, 16'hFFFF);
    repeat (3) tick();
    send_word(fmv_pkg::ACT_NOTE_OFF, '0, '0, '0);
    repeat (2) tick();
    drain();
    write_reg(fmv_pkg::REG_RELEASE_COEFF, '0);
    write_reg(fmv_pkg::REG_SILENCE_LEVEL, '1);
    send_word(fmv_pkg::ACT_NOTE_ON, $urandom, $urandom, 16'($urandom));
    tick();
    send_word(fmv_pkg::ACT_NOTE_OFF, '0, '0, '0);
    repeat (2) tick();
    drain();

    for (int ph = 0; items < ITEM_GOAL; ph++) begin
      set_regs(ph % 4);
      goal = items + $urandom_range(150, 300);
      while (items < goal && items < ITEM_GOAL) play_note();
      drain();
    end

    if (fails == 0 && pending == 0) begin
      $display("PASS fm_synth_voice");
    end else begin
      $display("FAIL fm_synth_voice");
    end
    $finish;
  end
endmodule

// File: filelist.f
src/fmv_pkg.sv
src/fmv_mul.sv
src/fm_synth_voice.sv
tb/fmv_checker.sv
tb/tb_top.sv
